// ===== src/rmsd_pkg.sv =====
// Shared types and constants for the running mean / standard deviation block.
// No dependencies.
package rmsd_pkg;

  localparam int SAMPLE_BITS = 32;  // significant bits of a sample, sign extended
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 32;

  localparam int DATA_W = 32;
  localparam int SUM_W  = 64;
  localparam int STEP_W = 7;

  // mean numerator is 33 bits, variance numerator is the full sum
  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = STEP_W'(DATA_W + 1);
  localparam logic [STEP_W-1:0] VAR_DIV_STEPS  = STEP_W'(SUM_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MEAN_DIV,
    S_MEAN_WAIT,
    S_MEAN,
    S_DEV,
    S_MUL,
    S_ACC,
    S_VAR_DIV,
    S_VAR_WAIT,
    S_ROOT,
    S_ROOT_WAIT,
    S_DONE
  } rmsd_state_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] x;
  } rmsd_head_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [DATA_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } rmsd_div_req_t;

endpackage

// ===== src/rmsd_front.sv =====
// Input side: two-beat sample queue with sign extension of the sample.
// Depends on rmsd_pkg.
module rmsd_front
  import rmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] sample,
  output rmsd_head_t        head,
  input  logic              take
);

  logic signed [SAMPLE_BITS-1:0] low;
  logic signed [DATA_W-1:0]      x_in;
  logic signed [DATA_W-1:0]      slot [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    fill;
  logic                          do_push;
  logic                          do_take;

  assign low     = sample[SAMPLE_BITS-1:0];
  assign x_in    = DATA_W'(low);
  assign full    = fill[1];
  assign do_push = push & ~full;
  assign do_take = take & head.valid;

  assign head.valid = (fill != 2'd0);
  assign head.x     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= x_in;
  end

endmodule

// ===== src/rmsd_divider.sv =====
// Restoring divider, one quotient bit per cycle; dividend register doubles as quotient.
// Depends on rmsd_pkg.
module rmsd_divider
  import rmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rmsd_div_req_t     req,
  output logic              busy,
  output logic [SUM_W-1:0]  quotient
);

  logic [SUM_W-1:0]  dvd;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsr;
  logic [STEP_W-1:0] left;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              fits;

  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr};
  assign fits     = ~diff[DATA_W+1];
  assign busy     = (left != '0);
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (req.start) begin
      left <= req.steps;
    end else if (busy) begin
      left <= left - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      dvd <= {dvd[SUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/rmsd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle (floor result).
// Depends on rmsd_pkg.
module rmsd_sqrt
  import rmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              busy,
  output logic [DATA_W-1:0] root
);

  logic [SUM_W-1:0]  rad;
  logic [DATA_W+1:0] rem;
  logic [5:0]        left;
  logic [DATA_W+3:0] rem_sh;
  logic [DATA_W+3:0] trial;
  logic [DATA_W+4:0] diff;
  logic              fits;

  assign rem_sh = {rem, rad[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign fits   = ~diff[DATA_W+4];
  assign busy   = (left != 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 6'd0;
    end else if (start) begin
      left <= 6'(DATA_W);
    end else if (busy) begin
      left <= left - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      // remainder stays below 2*root+1, so it fits back in its register
      rem  <= fits ? diff[DATA_W+1:0] : rem_sh[DATA_W+1:0];
      root <= {root[DATA_W-2:0], fits};
      rad  <= {rad[SUM_W-3:0], 2'b00};
    end
  end

endmodule

// ===== src/rmsd_back.sv =====
// Back end: sequencer for the Welford update, running state and the result register.
// Depends on rmsd_pkg, rmsd_divider and rmsd_sqrt.
module rmsd_back
  import rmsd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  rmsd_head_t               head,
  output logic                     take,
  input  logic                     pop,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] running_mean,
  output logic [DATA_W-1:0]        std_deviation,
  output logic [DATA_W-1:0]        sample_count,
  output logic                     saturated
);

  rmsd_state_t state, state_next;

  // running state
  logic signed [DATA_W-1:0] mean_reg;
  logic [SUM_W-1:0]         sum;
  logic [COUNT_BITS-1:0]    count_reg;
  logic                     flag;

  // per-sample working registers
  logic signed [DATA_W-1:0] x;
  logic [DATA_W-1:0]        m;
  logic                     at_max;
  logic [DATA_W-1:0]        mag;
  logic                     neg;
  logic signed [DATA_W-1:0] new_mean;
  logic [DATA_W-1:0]        dev;
  logic [SUM_W-1:0]         prod;
  logic [DATA_W-1:0]        std_reg;

  // control
  rmsd_div_req_t     div_req;
  logic              div_busy;
  logic [SUM_W-1:0]  quotient;
  logic              sqrt_start;
  logic              sqrt_busy;
  logic [DATA_W-1:0] root;
  logic              out_load;

  // datapath terms
  logic              count_full;
  logic [DATA_W:0]   d;
  logic [DATA_W:0]   e;
  logic [DATA_W:0]   num;
  logic [DATA_W-1:0] r;
  logic [SUM_W-1:0]  term;
  logic [SUM_W:0]    acc;
  logic              std_ovf;

  assign count_full = (count_reg == '1);
  assign d   = {x[DATA_W-1], x} - {mean_reg[DATA_W-1], mean_reg};
  assign e   = {x[DATA_W-1], x} - {new_mean[DATA_W-1], new_mean};
  assign num = {1'b0, mag} + {2'b00, m[DATA_W-1:1]};
  assign r   = quotient[DATA_W-1:0];
  assign term = prod >> FRAC_BITS;
  assign acc  = {1'b0, sum} + {1'b0, term};
  assign std_ovf = ((quotient >> (SUM_W - FRAC_BITS)) != '0);

  rmsd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quotient)
  );

  rmsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (quotient << FRAC_BITS),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (head.valid) state_next = S_DIFF;
      S_DIFF:      state_next = S_MEAN_DIV;
      S_MEAN_DIV:  state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: if (!div_busy) state_next = S_MEAN;
      S_MEAN:      state_next = S_DEV;
      S_DEV:       state_next = S_MUL;
      S_MUL:       state_next = S_ACC;
      S_ACC:       state_next = S_VAR_DIV;
      S_VAR_DIV:   state_next = S_VAR_WAIT;
      S_VAR_WAIT:  if (!div_busy) state_next = S_ROOT;
      S_ROOT:      state_next = std_ovf ? S_DONE : S_ROOT_WAIT;
      S_ROOT_WAIT: if (!sqrt_busy) state_next = S_DONE;
      S_DONE:      if (!out_valid || pop) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    take             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {num, {(SUM_W - DATA_W - 1){1'b0}}};
    div_req.divisor  = m;
    div_req.steps    = MEAN_DIV_STEPS;
    sqrt_start       = 1'b0;
    out_load         = 1'b0;
    unique case (state)
      S_IDLE:     take = head.valid;
      S_MEAN_DIV: div_req.start = 1'b1;
      S_VAR_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum;
        div_req.steps    = VAR_DIV_STEPS;
      end
      S_ROOT:     sqrt_start = ~std_ovf;
      S_DONE:     out_load = ~out_valid | pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mean_reg  <= '0;
      sum       <= '0;
      count_reg <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ACC) begin
        mean_reg  <= new_mean;
        sum       <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        count_reg <= m[COUNT_BITS-1:0];
        flag      <= flag | at_max | acc[SUM_W];
      end
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x      <= head.x;
      at_max <= count_full;
      m      <= count_full ? DATA_W'(count_reg) : DATA_W'(count_reg) + DATA_W'(1);
    end
    if (state == S_DIFF) begin
      neg <= d[DATA_W];
      mag <= d[DATA_W] ? DATA_W'(-d) : d[DATA_W-1:0];
    end
    // the rounded step never overshoots the sample, so 32-bit wrap is safe
    if (state == S_MEAN) new_mean <= neg ? mean_reg - r : mean_reg + r;
    if (state == S_DEV)  dev <= e[DATA_W] ? DATA_W'(-e) : e[DATA_W-1:0];
    if (state == S_MUL)  prod <= mag * dev;
    if (state == S_ROOT && std_ovf) std_reg <= '1;
    if (state == S_ROOT_WAIT && !sqrt_busy) std_reg <= root;
    if (out_load) begin
      running_mean  <= mean_reg;
      std_deviation <= std_reg;
      sample_count  <= DATA_W'(count_reg);
      saturated     <= flag;
    end
  end

endmodule

// ===== src/running_mean_std_deviation_top.sv =====
// Top level of the running mean / population standard deviation block.
// Depends on rmsd_pkg, rmsd_front and rmsd_back.

// Each sample (signed, 16 fraction bits) updates a Welford running mean, the sum of
// squared deviations and the count, and yields one result beat: the new mean, the
// population standard deviation sqrt(sum/count) and the count, with a sticky flag
// once the count or the sum saturates. Samples are handled one after another while
// the result register is free: a bit-serial divider works out the mean step and then
// sum/count, a bit-serial square root follows, and the sequencer steps through its
// own states around these units. When the deviation saturates the root is skipped.
// A finished result waits in the last step until the result register frees up. A
// two-beat input queue and a result register let the block take samples while a
// result waits to be popped.
module running_mean_std_deviation_top
  import rmsd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [DATA_W-1:0] sample,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] running_mean,
  output logic [DATA_W-1:0]        std_deviation,
  output logic [DATA_W-1:0]        sample_count,
  output logic                     saturated
);

  rmsd_head_t head;
  logic       take;
  logic       out_valid;

  assign empty = ~out_valid;

  rmsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .sample (sample),
    .head   (head),
    .take   (take)
  );

  rmsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .take          (take),
    .pop           (pop),
    .out_valid     (out_valid),
    .running_mean  (running_mean),
    .std_deviation (std_deviation),
    .sample_count  (sample_count),
    .saturated     (saturated)
  );

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> sample_count != '0)
    else $error("result beat with zero sample count");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && saturated) |=> (empty || saturated))
    else $error("saturation flag cleared");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    full |-> head.valid)
    else $error("queue full with no head beat");
`endif

endmodule
